// ===== rtl/custom_risc_integer_execute_defines.svh =====
// assertion macros for the integer execute block
`ifndef CUSTOM_RISC_INTEGER_EXECUTE_DEFINES_SVH
`define CUSTOM_RISC_INTEGER_EXECUTE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CRIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CRIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/crie_pkg.sv =====
// shared types and constants of the integer execute block
package crie_pkg;

  localparam int XLEN = 32;

  typedef enum logic [3:0] {
    OP_RTYPE  = 4'h1,
    OP_ITYPE  = 4'h2,
    OP_STORE  = 4'h3,
    OP_BRANCH = 4'h4,
    OP_LUI    = 4'h5,
    OP_AUIPC  = 4'h6,
    OP_JAL    = 4'h7,
    OP_JALR   = 4'h8,
    OP_LOAD   = 4'h9,
    OP_CSR    = 4'hB
  } opcode_e;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_MEM    = 2'd1,
    CLS_BRANCH = 2'd2
  } class_e;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_CSRW = 3'd1;
  localparam logic [2:0] F3_CSRR = 3'd2;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_SUB  = 7'h20;

  // register that csr in/out use
  localparam logic [5:0] REG_IO = 6'd10;

  typedef struct packed {
    logic [XLEN-1:0] pc_step;
    class_e          access_class;
    logic [5:0]      dest_reg;
    logic [5:0]      src1_reg;
    logic [5:0]      src2_reg;
    logic            out_valid;
    logic [XLEN-1:0] out_value;
  } result_t;

endpackage

// ===== rtl/crie_agu.sv =====
// address unit: signed word address reduced modulo the memory size, four stages
module crie_agu #(
  parameter int MEM_WORDS = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [crie_pkg::XLEN-1:0]    sum_i,
  output logic                         done_o,
  output logic [$clog2(MEM_WORDS)-1:0] idx_o
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int RW  = 34 - AW;
  localparam int P1W = 33 + RW;

  localparam longint WordsL = longint'(MEM_WORDS);
  localparam longint HalfL  = longint'(1) <<< 31;
  localparam longint OffsL  = WordsL * ((HalfL + WordsL - 1) / WordsL);
  localparam longint RecipL = (longint'(1) <<< 33) / WordsL;

  localparam logic [32:0]   OFFSET  = 33'(OffsL);
  localparam logic [RW-1:0] RECIP   = RW'(RecipL);
  localparam logic [32:0]   WORDS33 = 33'(WordsL);

  logic          v1_q, v2_q, v3_q, v4_q;
  logic [32:0]   u_q, u2_q, u3_q;
  logic [P1W-1:0] p1_q;
  logic [32:0]   p2_q;
  logic [RW-1:0] q_est;
  logic [32:0]   rem;
  logic [AW-1:0] idx_q;

  assign q_est = p1_q[P1W-1:33];
  assign rem   = u3_q - p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // offset is a multiple of the size that makes the sum non-negative
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= {sum_i[crie_pkg::XLEN-1], sum_i} + OFFSET;
    end
    if (v1_q) begin
      p1_q <= P1W'(u_q) * P1W'(RECIP);
      u2_q <= u_q;
    end
    if (v2_q) begin
      p2_q <= 33'(q_est) * WORDS33;
      u3_q <= u2_q;
    end
    // quotient estimate is at most one low, so one correction
    if (v3_q) begin
      idx_q <= (rem >= WORDS33) ? AW'(rem - WORDS33) : AW'(rem);
    end
  end

  assign done_o = v4_q;
  assign idx_o  = idx_q;

endmodule

// ===== rtl/custom_risc_integer_execute.sv =====
// integer execute block: register file and data memory in synchronous rams
// datapath: register-only words pass the execute stage and the output register, sw also
//   the address modulo unit, lw also the address unit and the load stage
// throughput: one word per cycle for register-only words while the output is not stalled;
//   sw and lw hold off the next word until done, set by the address unit and the single memory port
// reset: registers read zero; the data memory is cleared before the first word is accepted
`include "custom_risc_integer_execute_defines.svh"
module custom_risc_integer_execute #(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // instruction[31:0], line_index[47:32], io_value[79:48]
  input  logic [79:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pc_step[31:0], access_class[33:32], dest_reg[39:34], src1_reg[45:40],
  // src2_reg[51:46], out_value[83:52], zero[87:84]
  output logic [87:0] m_axis_tdata_o,
  // out_valid[0]
  output logic [0:0]  m_axis_tuser_o
);

  localparam int AW = $clog2(MEM_WORDS);

  // input word
  logic [31:0] in_ins;
  logic [15:0] in_line;
  logic [31:0] in_io;
  logic [5:0]  ra1, ra2;
  logic        ra1_ok, ra2_ok;
  logic        s_fire;

  // register file
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  logic [31:0] rd1_q, rd2_q, bypd1_q, bypd2_q;
  logic        byp1_q, byp2_q, zero1_q, zero2_q;

  // execute stage
  logic        ex_vld_q;
  logic [31:0] ex_ins_q;
  logic [15:0] ex_line_q;
  logic [31:0] ex_io_q;
  logic        agu_started_q, idx_rdy_q;
  logic [31:0] op_a, op_b;
  logic [3:0]  op;
  logic [5:0]  f_rd, f_rs1, f_rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [11:0] imm_i;
  logic [31:0] imm_i_sx, st_off_sx;
  logic [11:0] st_off;
  logic [12:0] br_imm, br_mag;
  logic [10:0] br_q;
  logic [31:0] br_step;
  logic        br_taken;
  logic [20:0] jal_imm;
  logic [31:0] jal_sx, jal_adj, jal_step;
  logic [31:0] jr_adj, jr_q, jr_tgt, jr_step;
  logic [31:0] line_ext;
  crie_pkg::result_t ex_res;
  logic        ex_we;
  logic [5:0]  ex_wreg;
  logic [31:0] ex_wd;
  logic        ex_is_store, ex_is_load, ex_is_mem;
  logic [31:0] mem_sum;
  logic        ex_idx_ok, ex_fin, ex_adv;

  // address unit
  logic          agu_start, agu_done;
  logic [AW-1:0] agu_idx;

  // data memory and clearing
  logic [31:0]   dmem [MEM_WORDS];
  logic          dm_we, dm_re;
  logic [AW-1:0] dm_addr;
  logic [31:0]   dm_wd, dm_rd_q;
  logic [AW-1:0] clr_cnt_q;
  logic          clr_done_q;

  // load stage and output register
  logic              mem_vld_q, mem_fin;
  logic [5:0]        mem_rd_q;
  crie_pkg::result_t mem_res_q;
  logic              out_vld_q, out_free;
  crie_pkg::result_t out_res_q;

  assign in_ins  = s_axis_tdata_i[31:0];
  assign in_line = s_axis_tdata_i[47:32];
  assign in_io   = s_axis_tdata_i[79:48];

  // csrw reads x10 through the first port
  assign ra1 = (in_ins[3:0] == crie_pkg::OP_CSR) ? crie_pkg::REG_IO : in_ins[18:13];
  assign ra2 = in_ins[24:19];
  assign ra1_ok = !ra1[5] && (ra1[4:0] != 5'd0);
  assign ra2_ok = !ra2[5] && (ra2[4:0] != 5'd0);

  // ---------------- register file ----------------
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (s_fire) begin
      rd1_q   <= rf_mem[ra1[4:0]];
      rd2_q   <= rf_mem[ra2[4:0]];
      // a write on the same edge is forwarded
      byp1_q  <= rf_we && (rf_wa == ra1[4:0]) && ra1_ok;
      byp2_q  <= rf_we && (rf_wa == ra2[4:0]) && ra2_ok;
      bypd1_q <= rf_wd;
      bypd2_q <= rf_wd;
      zero1_q <= !ra1_ok || !rf_vld_q[ra1[4:0]];
      zero2_q <= !ra2_ok || !rf_vld_q[ra2[4:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_wa] <= 1'b1;
    end
  end

  assign op_a = byp1_q ? bypd1_q : (zero1_q ? 32'd0 : rd1_q);
  assign op_b = byp2_q ? bypd2_q : (zero2_q ? 32'd0 : rd2_q);

  // ---------------- decode and execute ----------------
  assign op    = ex_ins_q[3:0];
  assign f_rd  = ex_ins_q[9:4];
  assign f3    = ex_ins_q[12:10];
  assign f_rs1 = ex_ins_q[18:13];
  assign f_rs2 = ex_ins_q[24:19];
  assign f7    = ex_ins_q[31:25];

  assign imm_i     = ex_ins_q[31:20];
  assign imm_i_sx  = {{20{imm_i[11]}}, imm_i};
  assign st_off    = {ex_ins_q[31:25], ex_ins_q[8:4]};
  assign st_off_sx = {{20{st_off[11]}}, st_off};
  assign line_ext  = {16'd0, ex_line_q};

  // branch offset magnitude, quarter truncated toward zero
  assign br_imm  = {ex_ins_q[31], ex_ins_q[4], ex_ins_q[30:25], ex_ins_q[8:5], 1'b0};
  assign br_mag  = br_imm[12] ? (13'd4096 - {1'b0, br_imm[11:0]}) : br_imm;
  assign br_q    = br_mag[12:2];
  assign br_step = br_imm[12] ? (32'd0 - {21'd0, br_q}) : {21'd0, br_q};

  always_comb begin
    unique case (f3)
      crie_pkg::F3_BEQ: br_taken = (op_a == op_b);
      crie_pkg::F3_BNE: br_taken = (op_a != op_b);
      crie_pkg::F3_BLT: br_taken = ($signed(op_a) < $signed(op_b));
      crie_pkg::F3_BGE: br_taken = ($signed(op_a) >= $signed(op_b));
      default:          br_taken = 1'b0;
    endcase
  end

  // divide by four toward zero: bias negatives by three, then shift
  assign jal_imm  = {ex_ins_q[31], ex_ins_q[19:12], ex_ins_q[20], ex_ins_q[30:21], 1'b0};
  assign jal_sx   = {{11{jal_imm[20]}}, jal_imm};
  assign jal_adj  = jal_sx + {30'd0, {2{jal_imm[20]}}};
  assign jal_step = {{2{jal_adj[31]}}, jal_adj[31:2]};

  assign jr_adj  = imm_i_sx + {30'd0, {2{imm_i[11]}}};
  assign jr_q    = {{2{jr_adj[31]}}, jr_adj[31:2]};
  assign jr_tgt  = op_a + jr_q;
  assign jr_step = jr_tgt - line_ext - 32'd1;

  always_comb begin
    ex_res              = '0;
    ex_res.pc_step      = 32'd1;
    ex_res.access_class = crie_pkg::CLS_OTHER;
    ex_we               = 1'b0;
    ex_wreg             = f_rd;
    ex_wd               = '0;
    ex_is_store         = 1'b0;
    ex_is_load          = 1'b0;
    mem_sum             = op_a + imm_i_sx;
    unique case (crie_pkg::opcode_e'(op))
      crie_pkg::OP_RTYPE: begin
        ex_res.dest_reg = f_rd;
        ex_res.src1_reg = f_rs1;
        ex_res.src2_reg = f_rs2;
        priority if (f3 == crie_pkg::F3_ADD && f7 == crie_pkg::F7_BASE) begin
          ex_we = 1'b1;
          ex_wd = op_a + op_b;
        end else if (f3 == crie_pkg::F3_ADD && f7 == crie_pkg::F7_SUB) begin
          ex_we = 1'b1;
          ex_wd = op_a - op_b;
        end else if (f3 == crie_pkg::F3_AND && f7 == crie_pkg::F7_BASE) begin
          ex_we = 1'b1;
          ex_wd = op_a & op_b;
        end else if (f3 == crie_pkg::F3_OR && f7 == crie_pkg::F7_BASE) begin
          ex_we = 1'b1;
          ex_wd = op_a | op_b;
        end else if (f3 == crie_pkg::F3_XOR && f7 == crie_pkg::F7_BASE) begin
          ex_we = 1'b1;
          ex_wd = op_a ^ op_b;
        end else begin
          ex_we = 1'b0;
        end
      end
      crie_pkg::OP_ITYPE: begin
        ex_res.dest_reg = f_rd;
        ex_res.src1_reg = f_rs1;
        // negative immediate: only addi acts
        priority if (f3 == crie_pkg::F3_ADD) begin
          ex_we = 1'b1;
          ex_wd = op_a + imm_i_sx;
        end else if (imm_i[11]) begin
          ex_we = 1'b0;
        end else if (f3 == crie_pkg::F3_AND) begin
          ex_we = 1'b1;
          ex_wd = op_a & {20'd0, imm_i};
        end else if (f3 == crie_pkg::F3_OR) begin
          ex_we = 1'b1;
          ex_wd = op_a | {20'd0, imm_i};
        end else if (f3 == crie_pkg::F3_XOR) begin
          ex_we = 1'b1;
          ex_wd = op_a ^ {20'd0, imm_i};
        end else if (f3 == crie_pkg::F3_SLL) begin
          ex_we = 1'b1;
          ex_wd = (imm_i[11:5] == 7'd0) ? (op_a << imm_i[4:0]) : 32'd0;
        end else begin
          ex_we = 1'b0;
        end
      end
      crie_pkg::OP_STORE: begin
        ex_res.access_class = crie_pkg::CLS_MEM;
        ex_res.src1_reg     = f_rs1;
        ex_res.src2_reg     = f_rs2;
        ex_is_store         = 1'b1;
        mem_sum             = op_a + st_off_sx;
      end
      crie_pkg::OP_BRANCH: begin
        ex_res.access_class = crie_pkg::CLS_BRANCH;
        ex_res.src1_reg     = f_rs1;
        ex_res.src2_reg     = f_rs2;
        ex_res.pc_step      = (br_taken && (br_q != 11'd0)) ? br_step : 32'd1;
      end
      crie_pkg::OP_LUI: begin
        ex_res.dest_reg = f_rd;
        ex_we           = 1'b1;
        ex_wd           = {ex_ins_q[31:12], 12'd0};
      end
      crie_pkg::OP_AUIPC: begin
        ex_res.dest_reg = f_rd;
        ex_we           = 1'b1;
        ex_wd           = line_ext + {{2{ex_ins_q[31]}}, ex_ins_q[31:12], 10'd0};
      end
      crie_pkg::OP_JAL: begin
        ex_res.dest_reg = f_rd;
        ex_res.pc_step  = jal_step;
        ex_we           = 1'b1;
        ex_wd           = line_ext + 32'd2;
      end
      crie_pkg::OP_JALR: begin
        ex_res.dest_reg = f_rd;
        ex_res.src1_reg = f_rs1;
        ex_res.pc_step  = (jr_step == 32'd0) ? 32'd1 : jr_step;
        ex_we           = 1'b1;
        ex_wd           = jr_tgt;
      end
      crie_pkg::OP_LOAD: begin
        ex_res.access_class = crie_pkg::CLS_MEM;
        ex_res.dest_reg     = f_rd;
        ex_res.src1_reg     = f_rs1;
        ex_is_load          = 1'b1;
      end
      crie_pkg::OP_CSR: begin
        priority if (f3 == crie_pkg::F3_CSRW) begin
          ex_res.out_valid = 1'b1;
          ex_res.out_value = op_a;
          ex_res.src1_reg  = crie_pkg::REG_IO;
        end else if (f3 == crie_pkg::F3_CSRR) begin
          ex_res.dest_reg = crie_pkg::REG_IO;
          ex_we           = 1'b1;
          ex_wreg         = crie_pkg::REG_IO;
          ex_wd           = ex_io_q;
        end else begin
          ex_we = 1'b0;
        end
      end
      default: begin
        ex_we = 1'b0;
      end
    endcase
  end

  assign ex_is_mem = ex_is_store || ex_is_load;

  // ---------------- handshakes and stage control ----------------
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign mem_fin   = mem_vld_q && out_free;
  assign ex_idx_ok = idx_rdy_q || agu_done;
  assign ex_fin    = ex_vld_q && !ex_is_load && !mem_vld_q && out_free
                     && (!ex_is_store || ex_idx_ok);
  assign ex_adv    = ex_vld_q && ex_is_load && ex_idx_ok && (!mem_vld_q || mem_fin);
  assign agu_start = ex_vld_q && ex_is_mem && !agu_started_q;

  // a load blocks the next word until its write-back edge, which is forwarded
  assign s_axis_tready_o = clr_done_q && (!ex_vld_q || ex_fin) && (!mem_vld_q || mem_fin);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (mem_fin) begin
      rf_we = !mem_rd_q[5] && (mem_rd_q[4:0] != 5'd0);
      rf_wa = mem_rd_q[4:0];
      rf_wd = dm_rd_q;
    end else begin
      rf_we = ex_fin && ex_we && !ex_wreg[5] && (ex_wreg[4:0] != 5'd0);
      rf_wa = ex_wreg[4:0];
      rf_wd = ex_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q      <= 1'b0;
      agu_started_q <= 1'b0;
      idx_rdy_q     <= 1'b0;
      mem_vld_q     <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      if (s_fire) begin
        ex_vld_q <= 1'b1;
      end else if (ex_fin || ex_adv) begin
        ex_vld_q <= 1'b0;
      end
      if (s_fire) begin
        agu_started_q <= 1'b0;
      end else if (agu_start) begin
        agu_started_q <= 1'b1;
      end
      if (s_fire) begin
        idx_rdy_q <= 1'b0;
      end else if (agu_done) begin
        idx_rdy_q <= 1'b1;
      end
      if (ex_adv) begin
        mem_vld_q <= 1'b1;
      end else if (mem_fin) begin
        mem_vld_q <= 1'b0;
      end
      if (ex_fin || mem_fin) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ex_ins_q  <= in_ins;
      ex_line_q <= in_line;
      ex_io_q   <= in_io;
    end
    if (ex_adv) begin
      mem_rd_q  <= f_rd;
      mem_res_q <= ex_res;
    end
    if (mem_fin) begin
      out_res_q <= mem_res_q;
    end else if (ex_fin) begin
      out_res_q <= ex_res;
    end
  end

  crie_agu #(
    .MEM_WORDS(MEM_WORDS)
  ) u_agu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(agu_start),
    .sum_i  (mem_sum),
    .done_o (agu_done),
    .idx_o  (agu_idx)
  );

  // ---------------- data memory ----------------
  assign dm_we   = !clr_done_q || (ex_fin && ex_is_store);
  assign dm_re   = ex_adv;
  assign dm_addr = clr_done_q ? agu_idx : clr_cnt_q;
  assign dm_wd   = clr_done_q ? op_b : 32'd0;

  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dmem[dm_addr] <= dm_wd;
    end
    if (dm_re) begin
      dm_rd_q <= dmem[dm_addr];
    end
  end

  // one word cleared per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      if (clr_cnt_q == AW'(MEM_WORDS - 1)) begin
        clr_done_q <= 1'b1;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // ---------------- outputs ----------------
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_res_q.out_value, out_res_q.src2_reg,
                            out_res_q.src1_reg, out_res_q.dest_reg,
                            out_res_q.access_class, out_res_q.pc_step};
  assign m_axis_tuser_o  = out_res_q.out_valid;

  // ---------------- assertions ----------------
  `CRIE_ASSERT_NOW(a_one_stage, ex_vld_q, !mem_vld_q, "execute and load stages both occupied")
  `CRIE_ASSERT_NOW(a_clear_gate, s_fire, clr_done_q, "word accepted during memory clear")
  `CRIE_ASSERT_NOW(a_agu_owner, agu_done, ex_vld_q && ex_is_mem && !idx_rdy_q, "stray address")
  `CRIE_ASSERT_NEXT(a_out_shown, ex_fin || mem_fin, m_axis_tvalid_o, "finished word not shown")

endmodule

// ===== tb/tb_custom_risc_integer_execute.sv =====
// testbench for the integer execute block: random and directed words against a predictor
`timescale 1ns / 1ps
module tb_custom_risc_integer_execute;

  localparam int MEM_WORDS = 65536;
  localparam int WORD_COUNT = 1950;
  localparam logic [3:0] OP_LABEL = 4'h0;
  localparam logic [3:0] OP_FLOAT = 4'hA;
  localparam logic [3:0] OP_SPARE_LO = 4'hC;
  localparam logic [2:0] F3_SPARE = 3'd3;
  localparam logic [6:0] F7_SPARE = 7'h01;

  typedef struct packed {
    logic [31:0] io;
    logic [15:0] line;
    logic [31:0] instr;
  } exec_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [79:0] s_data = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [87:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  custom_risc_integer_execute dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  bit [31:0] gpr [32];
  bit [31:0] dmem [MEM_WORDS];

  exec_item_t pending_words[$];
  crie_pkg::result_t predicted_results[$];
  exec_item_t next_word;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_mem = 0;
  int n_taken = 0;
  int n_csr_out = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic logic [31:0] read_gpr(input logic [5:0] n);
    return (n >= 1 && n < 32) ? gpr[n[4:0]] : 32'h0;
  endfunction

  function automatic void write_gpr(input logic [5:0] n, input logic [31:0] v);
    if (n >= 1 && n < 32) gpr[n[4:0]] = v;
  endfunction

  function automatic logic [31:0] imm12_value(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // memory size is a power of two, so the signed wrap keeps the low address bits
  function automatic int mem_slot(input logic [31:0] base, input logic [11:0] off);
    logic [31:0] addr;
    addr = base + imm12_value(off);
    return int'(addr % MEM_WORDS);
  endfunction

  function automatic crie_pkg::result_t execute_word(input logic [31:0] ins,
                                                     input logic [15:0] line,
                                                     input logic [31:0] io);
    logic [3:0]  op;
    logic [5:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, imm, tgt;
    logic [12:0] boff;
    logic [20:0] joff;
    logic        taken;
    int          step, iv;
    crie_pkg::result_t r;
    op = ins[3:0];
    rd = ins[9:4];
    f3 = ins[12:10];
    rs1 = ins[18:13];
    rs2 = ins[24:19];
    f7 = ins[31:25];
    a = read_gpr(rs1);
    b = read_gpr(rs2);
    step = 1;
    r = '0;
    r.access_class = crie_pkg::CLS_OTHER;
    case (op)
      crie_pkg::OP_RTYPE: begin
        r.dest_reg = rd; r.src1_reg = rs1; r.src2_reg = rs2;
        if (f3 == crie_pkg::F3_ADD && f7 == crie_pkg::F7_BASE) write_gpr(rd, a + b);
        else if (f3 == crie_pkg::F3_ADD && f7 == crie_pkg::F7_SUB) write_gpr(rd, a - b);
        else if (f3 == crie_pkg::F3_AND && f7 == crie_pkg::F7_BASE) write_gpr(rd, a & b);
        else if (f3 == crie_pkg::F3_OR && f7 == crie_pkg::F7_BASE) write_gpr(rd, a | b);
        else if (f3 == crie_pkg::F3_XOR && f7 == crie_pkg::F7_BASE) write_gpr(rd, a ^ b);
      end
      crie_pkg::OP_ITYPE: begin
        imm = {20'h0, ins[31:20]};
        r.dest_reg = rd; r.src1_reg = rs1;
        if (!imm[11]) begin
          if (f3 == crie_pkg::F3_ADD) write_gpr(rd, a + imm);
          else if (f3 == crie_pkg::F3_AND) write_gpr(rd, a & imm);
          else if (f3 == crie_pkg::F3_OR) write_gpr(rd, a | imm);
          else if (f3 == crie_pkg::F3_XOR) write_gpr(rd, a ^ imm);
          else if (f3 == crie_pkg::F3_SLL) write_gpr(rd, imm < 32 ? a << imm : 32'h0);
        end else if (f3 == crie_pkg::F3_ADD) begin
          // negative immediates only act for addi
          write_gpr(rd, a + imm12_value(imm[11:0]));
        end
      end
      crie_pkg::OP_STORE: begin
        r.access_class = crie_pkg::CLS_MEM; r.src1_reg = rs1; r.src2_reg = rs2;
        dmem[mem_slot(a, {ins[31:25], ins[8:4]})] = b;
      end
      crie_pkg::OP_BRANCH: begin
        boff = {ins[31], ins[4], ins[30:25], ins[8:5], 1'b0};
        r.access_class = crie_pkg::CLS_BRANCH; r.src1_reg = rs1; r.src2_reg = rs2;
        case (f3)
          crie_pkg::F3_BEQ: taken = (a == b);
          crie_pkg::F3_BNE: taken = (a != b);
          crie_pkg::F3_BLT: taken = ($signed(a) < $signed(b));
          crie_pkg::F3_BGE: taken = ($signed(a) >= $signed(b));
          default: taken = 1'b0;
        endcase
        iv = {{19{boff[12]}}, boff};
        step = taken ? iv / 4 : 1;
        if (step == 0) step = 1;
      end
      crie_pkg::OP_LUI: begin
        r.dest_reg = rd;
        write_gpr(rd, {ins[31:12], 12'h0});
      end
      crie_pkg::OP_AUIPC: begin
        r.dest_reg = rd;
        iv = {ins[31:12], 12'h0};
        write_gpr(rd, 32'(line) + 32'(iv / 4));
      end
      crie_pkg::OP_JAL: begin
        joff = {ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        r.dest_reg = rd;
        write_gpr(rd, 32'(line) + 32'd2);
        iv = {{11{joff[20]}}, joff};
        // a zero step stays zero here
        step = iv / 4;
      end
      crie_pkg::OP_JALR: begin
        r.dest_reg = rd; r.src1_reg = rs1;
        iv = imm12_value(ins[31:20]);
        tgt = a + 32'(iv / 4);
        write_gpr(rd, tgt);
        step = tgt - 32'(line) - 32'd1;
        if (step == 0) step = 1;
      end
      crie_pkg::OP_LOAD: begin
        r.access_class = crie_pkg::CLS_MEM; r.dest_reg = rd; r.src1_reg = rs1;
        write_gpr(rd, dmem[mem_slot(a, ins[31:20])]);
      end
      crie_pkg::OP_CSR: begin
        if (f3 == crie_pkg::F3_CSRW) begin
          r.out_valid = 1'b1;
          r.out_value = read_gpr(crie_pkg::REG_IO);
          r.src1_reg = crie_pkg::REG_IO;
        end else if (f3 == crie_pkg::F3_CSRR) begin
          write_gpr(crie_pkg::REG_IO, io);
          r.dest_reg = crie_pkg::REG_IO;
        end
      end
      default: ;
    endcase
    r.pc_step = step;
    return r;
  endfunction

  function automatic logic [31:0] word_rr(input logic [3:0] op, input logic [5:0] rd,
                                          input logic [2:0] f3, input logic [5:0] rs1,
                                          input logic [5:0] rs2, input logic [6:0] f7);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] word_ri(input logic [3:0] op, input logic [5:0] rd,
                                          input logic [2:0] f3, input logic [5:0] rs1,
                                          input logic [11:0] imm);
    logic [31:0] w;
    w = word_rr(op, rd, f3, rs1, '0, '0);
    w[31:20] = imm;
    return w;
  endfunction

  function automatic logic [31:0] word_br(input logic [2:0] f3, input logic [5:0] rs1,
                                          input logic [5:0] rs2, input logic [12:0] imm);
    logic [31:0] w;
    w = word_rr(crie_pkg::OP_BRANCH, '0, f3, rs1, rs2, '0);
    {w[31], w[4], w[30:25], w[8:5]} = imm[12:1];
    return w;
  endfunction

  task automatic queue_word(input logic [31:0] w, input logic [31:0] io);
    exec_item_t it;
    it.instr = w;
    it.line = 16'($urandom());
    it.io = io;
    pending_words.push_back(it);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    end
  endtask

  // sender: new word once the current one is taken, with random gaps outside a gap-free run
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        next_word = s_data;
        predicted_results.push_back(execute_word(next_word.instr, next_word.line,
                                                 next_word.io));
        n_accepted++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (pending_words.size() != 0 &&
            ((n_accepted >= 900 && n_accepted < 1300) || $urandom_range(0, 99) >= 11)) begin
          next_word = pending_words.pop_front();
          s_valid <= 1'b1;
          s_data <= next_word;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each word, random stalls outside a stall-free run and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    crie_pkg::result_t want, got;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        got.pc_step = m_axis_tdata_o[31:0];
        got.access_class = crie_pkg::class_e'(m_axis_tdata_o[33:32]);
        got.dest_reg = m_axis_tdata_o[39:34];
        got.src1_reg = m_axis_tdata_o[45:40];
        got.src2_reg = m_axis_tdata_o[51:46];
        got.out_value = m_axis_tdata_o[83:52];
        got.out_valid = m_axis_tuser_o[0];
        n_results++;
        if (predicted_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word, expected none got %h", $time, m_axis_tdata_o);
        end else begin
          want = predicted_results.pop_front();
          check_field("pc_step", want.pc_step, got.pc_step);
          check_field("access_class", 32'(want.access_class), 32'(got.access_class));
          check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
          check_field("src1_reg", 32'(want.src1_reg), 32'(got.src1_reg));
          check_field("src2_reg", 32'(want.src2_reg), 32'(got.src2_reg));
          check_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
          check_field("out_value", want.out_value, got.out_value);
          if (want.access_class == crie_pkg::CLS_MEM) n_mem++;
          if (want.access_class == crie_pkg::CLS_BRANCH && want.pc_step != 1) n_taken++;
          if (want.out_valid) n_csr_out++;
        end
      end
      if (!hold_done && n_results == 500) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= (n_results >= 1100 && n_results < 1400) || $urandom_range(0, 99) >= 11;
      end
    end
  end

  initial begin
    logic [31:0] w;
    logic [11:0] off;
    int pick;

    // directed words: extremes and corner cases
    queue_word({20'hFFFFF, 12'h0} | word_rr(crie_pkg::OP_LUI, 6'd1, '0, '0, '0, '0),
               $urandom());
    queue_word(word_ri(crie_pkg::OP_ITYPE, 6'd2, crie_pkg::F3_ADD, 6'd0, 12'h7FF),
               $urandom());
    queue_word(word_ri(crie_pkg::OP_ITYPE, 6'd3, crie_pkg::F3_ADD, 6'd1, 12'h800),
               $urandom());
    queue_word(word_ri(crie_pkg::OP_ITYPE, 6'd2, crie_pkg::F3_AND, 6'd1, 12'hFFF),
               $urandom());
    queue_word(word_ri(crie_pkg::OP_ITYPE, 6'd5, crie_pkg::F3_SLL, 6'd2, 12'd40),
               $urandom());
    queue_word(word_ri(crie_pkg::OP_ITYPE, 6'd6, F3_SPARE, 6'd2, 12'd5), $urandom());
    queue_word(word_rr(crie_pkg::OP_RTYPE, 6'd7, crie_pkg::F3_ADD, 6'd1, 6'd2,
                       crie_pkg::F7_BASE), $urandom());
    queue_word(word_rr(crie_pkg::OP_RTYPE, 6'd8, crie_pkg::F3_ADD, 6'd2, 6'd1,
                       crie_pkg::F7_SUB), $urandom());
    queue_word(word_rr(crie_pkg::OP_RTYPE, 6'd40, crie_pkg::F3_AND, 6'd1, 6'd2,
                       crie_pkg::F7_BASE), $urandom());
    queue_word(word_rr(crie_pkg::OP_RTYPE, 6'd9, crie_pkg::F3_OR, 6'd33, 6'd2,
                       crie_pkg::F7_BASE), $urandom());
    queue_word(word_rr(crie_pkg::OP_RTYPE, 6'd0, crie_pkg::F3_XOR, 6'd1, 6'd2,
                       crie_pkg::F7_BASE), $urandom());
    queue_word(word_rr(crie_pkg::OP_RTYPE, 6'd12, crie_pkg::F3_ADD, 6'd1, 6'd2, F7_SPARE),
               $urandom());
    // store then load at offset -1, wrapping to the top of memory
    queue_word(word_rr(crie_pkg::OP_STORE, 6'h1F, '0, 6'd0, 6'd1, 7'h7F), $urandom());
    queue_word(word_ri(crie_pkg::OP_LOAD, 6'd11, '0, 6'd0, 12'hFFF), $urandom());
    queue_word(word_br(crie_pkg::F3_BEQ, 6'd0, 6'd0, 13'h1000), $urandom());
    queue_word(word_br(crie_pkg::F3_BNE, 6'd1, 6'd2, 13'h0FFE), $urandom());
    queue_word(word_br(crie_pkg::F3_BLT, 6'd1, 6'd2, 13'd2), $urandom());
    queue_word(word_br(crie_pkg::F3_BGE, 6'd1, 6'd2, 13'h1FFC), $urandom());
    queue_word(word_br(F3_SPARE, 6'd0, 6'd0, 13'd8), $urandom());
    queue_word(word_rr(crie_pkg::OP_JAL, 6'd13, '0, '0, '0, '0), $urandom());
    queue_word(32'h8000_0000 | word_rr(crie_pkg::OP_JAL, 6'd14, '0, '0, '0, '0),
               $urandom());
    queue_word(word_ri(crie_pkg::OP_JALR, 6'd15, '0, 6'd2, 12'h800), $urandom());
    queue_word({20'h80000, 12'h0} | word_rr(crie_pkg::OP_AUIPC, 6'd16, '0, '0, '0, '0),
               $urandom());
    queue_word(word_rr(crie_pkg::OP_CSR, '0, crie_pkg::F3_CSRR, '0, '0, '0), 32'h8000_0000);
    queue_word(word_rr(crie_pkg::OP_CSR, '0, crie_pkg::F3_CSRW, '0, '0, '0), 32'h7FFF_FFFF);
    queue_word(word_rr(crie_pkg::OP_CSR, '0, crie_pkg::F3_CSRR, '0, '0, '0), 32'h7FFF_FFFF);
    queue_word(word_rr(OP_FLOAT, 6'd63, '0, 6'd1, 6'd2, '0), $urandom());

    for (int k = 0; k < WORD_COUNT; k++) begin
      w = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        w[3:0] = crie_pkg::OP_RTYPE;
        case ($urandom_range(0, 5))
          0: {w[31:25], w[12:10]} = {crie_pkg::F7_BASE, crie_pkg::F3_ADD};
          1: {w[31:25], w[12:10]} = {crie_pkg::F7_SUB, crie_pkg::F3_ADD};
          2: {w[31:25], w[12:10]} = {crie_pkg::F7_BASE, crie_pkg::F3_AND};
          3: {w[31:25], w[12:10]} = {crie_pkg::F7_BASE, crie_pkg::F3_OR};
          4: {w[31:25], w[12:10]} = {crie_pkg::F7_BASE, crie_pkg::F3_XOR};
          default: ;
        endcase
      end else if (pick < 33) begin
        w[3:0] = crie_pkg::OP_ITYPE;
        case ($urandom_range(0, 5))
          0: w[12:10] = crie_pkg::F3_ADD;
          1: w[12:10] = crie_pkg::F3_AND;
          2: w[12:10] = crie_pkg::F3_OR;
          3: w[12:10] = crie_pkg::F3_XOR;
          4: w[12:10] = crie_pkg::F3_SLL;
          default: ;
        endcase
        case ($urandom_range(0, 2))
          0: w[31:20] = 12'($urandom_range(0, 40));
          1: w[31] = 1'b1;
          default: ;
        endcase
      end else if (pick < 53) begin
        w[3:0] = (pick < 43) ? crie_pkg::OP_STORE : crie_pkg::OP_LOAD;
        // half the accesses go near address zero so loads find earlier stores
        if ($urandom_range(0, 1) != 0) begin
          w[18:13] = '0;
          off = 12'($urandom_range(0, 31)) - 12'd16;
          if (pick < 43) {w[31:25], w[8:4]} = off;
          else w[31:20] = off;
        end
      end else if (pick < 63) begin
        w[3:0] = crie_pkg::OP_BRANCH;
        case ($urandom_range(0, 4))
          0: w[12:10] = crie_pkg::F3_BEQ;
          1: w[12:10] = crie_pkg::F3_BNE;
          2: w[12:10] = crie_pkg::F3_BLT;
          3: w[12:10] = crie_pkg::F3_BGE;
          default: ;
        endcase
        if ($urandom_range(0, 3) == 0) w[24:19] = w[18:13];
      end else if (pick < 68) begin
        w[3:0] = crie_pkg::OP_LUI;
      end else if (pick < 72) begin
        w[3:0] = crie_pkg::OP_AUIPC;
      end else if (pick < 76) begin
        w[3:0] = crie_pkg::OP_JAL;
      end else if (pick < 81) begin
        w[3:0] = crie_pkg::OP_JALR;
      end else if (pick < 90) begin
        w[3:0] = crie_pkg::OP_CSR;
        case ($urandom_range(0, 2))
          0: w[12:10] = crie_pkg::F3_CSRW;
          1: w[12:10] = crie_pkg::F3_CSRR;
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: w[3:0] = OP_LABEL;
          1: w[3:0] = OP_FLOAT;
          default: w[3:0] = OP_SPARE_LO + 4'($urandom_range(0, 3));
        endcase
      end
      // mostly integer register numbers
      if ($urandom_range(0, 9) != 0) w[9] = 1'b0;
      if ($urandom_range(0, 9) != 0) w[18] = 1'b0;
      if ((w[3:0] == crie_pkg::OP_RTYPE || w[3:0] == crie_pkg::OP_BRANCH ||
           w[3:0] == crie_pkg::OP_STORE) && $urandom_range(0, 9) != 0) w[24] = 1'b0;
      queue_word(w, $urandom());
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || s_valid) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d words executed: %0d loads/stores, %0d taken branches, %0d csr outputs",
             n_results, n_mem, n_taken, n_csr_out);
    $display("%0d mismatches", n_errors);
    if (n_errors == 0) begin
      $display("tb_custom_risc_integer_execute OK");
    end else begin
      $display("tb_custom_risc_integer_execute NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout after %0d of %0d words", n_results, n_accepted);
    $display("tb_custom_risc_integer_execute NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/crie_pkg.sv
rtl/crie_agu.sv
rtl/custom_risc_integer_execute.sv
tb/tb_custom_risc_integer_execute.sv
